### hdl/npa_pkg.sv
package npa_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int GRANT_LIMIT = (TABLE_DEPTH < MAX_RESULTS) ? TABLE_DEPTH : MAX_RESULTS;
  localparam int LIM_W = $clog2(GRANT_LIMIT + 1);

  localparam int CMD_W = 2;
  localparam int IDENT_W = 16;
  localparam int WANT_W = 5;
  localparam int CODE_W = 2;
  localparam int TOTAL_W = 5;
  localparam int POOL_W = 5;

  localparam int IN_USED_W = IDENT_W + WANT_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W = CODE_W + IDENT_W + TOTAL_W + POOL_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ALLOC  = 2'd2
  } cmd_t;

  typedef enum logic [CODE_W-1:0] {
    RC_OK       = 2'd0,
    RC_FULL     = 2'd1,
    RC_NOTFOUND = 2'd2
  } rc_t;

  typedef enum logic [2:0] {
    KIND_OK,
    KIND_FULL,
    KIND_NOTFOUND,
    KIND_GRANT_MID,
    KIND_GRANT_LAST,
    KIND_NO_GRANT
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_PRIME,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      scan_adv;
    logic      fetch_last;
    logic      hit_cap;
    logic      add_wr;
    logic      move_wr;
    logic      grant;
    logic      emit;
    out_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    cmd_t in_cmd;
    logic data_vld;
    logic hit;
    logic entry_free;
    logic made_eq_limit;
    logic pend_vld;
    logic count_full;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/npa_datapath.sv
module npa_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [npa_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [npa_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           out_tready,
  input  npa_pkg::ctrl_cmd_t             ctrl,
  output npa_pkg::dp_status_t            status,
  output logic                           out_tvalid,
  output logic [npa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast
);
  import npa_pkg::*;

  logic [IDENT_W:0] mem [TABLE_DEPTH];
  logic [IDENT_W:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDENT_W:0] wr_data;
  logic             wr_en;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_ptr_r;
  logic [IDX_W-1:0]   chk_ptr_r;
  logic [IDX_W-1:0]   hit_ptr_r;
  logic               data_vld_r;
  logic [IDENT_W-1:0] ident_r;
  cmd_t               cmd_r;
  logic [LIM_W-1:0]   limit_r;
  logic [LIM_W-1:0]   made_r;
  logic               pend_vld_r;
  logic [IDENT_W-1:0] pend_ident_r;
  logic [LIM_W-1:0]   pend_total_r;

  logic               out_valid_r;
  rc_t                out_code_r;
  logic [IDENT_W-1:0] out_ident_r;
  logic               out_gvalid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [POOL_W-1:0]  out_pool_r;
  logic               out_last_r;

  logic               out_free;
  logic [WANT_W-1:0]  want;

  assign want     = in_tdata[IDENT_W +: WANT_W];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    rd_en   = ctrl.scan_adv || ctrl.fetch_last;
    rd_addr = ctrl.fetch_last ? IDX_W'(count_r - 1'b1) : rd_ptr_r[IDX_W-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_ptr_r;
    wr_data = {1'b1, rd_data_r[IDENT_W-1:0]};
    if (ctrl.add_wr) begin
      wr_en   = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_data = {1'b0, ident_r};
    end else if (ctrl.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = hit_ptr_r;
      wr_data = rd_data_r;
    end else if (ctrl.grant) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.add_wr) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.move_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      data_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      made_r      <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctrl.load_in) begin
        data_vld_r <= 1'b0;
        pend_vld_r <= 1'b0;
        made_r     <= '0;
        limit_r    <= (32'(want) > GRANT_LIMIT) ? LIM_W'(GRANT_LIMIT) : LIM_W'(want);
      end else begin
        if (ctrl.scan_adv) begin
          data_vld_r <= rd_ptr_r < count_r;
        end
        if (ctrl.grant) begin
          made_r     <= made_r + 1'b1;
          pend_vld_r <= 1'b1;
        end
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      ident_r  <= in_tdata[IDENT_W-1:0];
      cmd_r    <= cmd_t'(in_tuser);
      rd_ptr_r <= '0;
    end else if (ctrl.scan_adv) begin
      rd_ptr_r  <= rd_ptr_r + 1'b1;
      chk_ptr_r <= rd_ptr_r[IDX_W-1:0];
    end
    if (ctrl.hit_cap) begin
      hit_ptr_r <= chk_ptr_r;
    end
    if (ctrl.grant) begin
      pend_ident_r <= rd_data_r[IDENT_W-1:0];
      pend_total_r <= made_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_code_r   <= RC_OK;
      out_ident_r  <= '0;
      out_gvalid_r <= 1'b0;
      out_total_r  <= '0;
      out_pool_r   <= POOL_W'(count_nxt);
      out_last_r   <= 1'b1;
      case (ctrl.kind)
        KIND_OK: begin
        end
        KIND_FULL: begin
          out_code_r <= RC_FULL;
        end
        KIND_NOTFOUND: begin
          out_code_r <= RC_NOTFOUND;
        end
        KIND_GRANT_MID, KIND_GRANT_LAST: begin
          out_ident_r  <= pend_ident_r;
          out_gvalid_r <= 1'b1;
          out_total_r  <= TOTAL_W'(pend_total_r);
          out_last_r   <= ctrl.kind == KIND_GRANT_LAST;
        end
        KIND_NO_GRANT: begin
        end
        default: begin
          out_code_r <= RC_NOTFOUND;
        end
      endcase
    end
  end

  always_comb begin
    status.cmd           = cmd_r;
    status.in_cmd        = cmd_t'(in_tuser);
    status.data_vld      = data_vld_r;
    status.hit           = rd_data_r[IDENT_W-1:0] == ident_r;
    status.entry_free    = !rd_data_r[IDENT_W];
    status.made_eq_limit = made_r == limit_r;
    status.pend_vld      = pend_vld_r;
    status.count_full    = count_r == CNT_W'(TABLE_DEPTH);
    status.out_free      = out_free;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_pool_r, out_total_r,
                       out_ident_r, out_code_r};
  assign out_tuser  = out_gvalid_r;
  assign out_tlast  = out_last_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> out_free)
    else $error("Result loaded while the output register was still occupied.");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.move_wr |-> count_r != '0)
    else $error("Remove shrank an empty table.");

  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.grant |-> data_vld_r && !rd_data_r[IDENT_W] && made_r < limit_r)
    else $error("Grant issued on a busy, invalid or surplus entry.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.add_wr |=> count_r == $past(count_r) + 1'b1 && count_r <= CNT_W'(TABLE_DEPTH))
    else $error("Add pushed the entry count out of range.");

endmodule

### hdl/npa_ctrl.sv
module npa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  npa_pkg::dp_status_t status,
  output npa_pkg::ctrl_cmd_t  ctrl
);
  import npa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ctrl      = '0;
    ctrl.kind = KIND_OK;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load_in = 1'b1;
          case (status.in_cmd)
            CMD_ADD: begin
              state_nxt = ST_ADD;
            end
            CMD_REMOVE, CMD_ALLOC: begin
              state_nxt = ST_PRIME;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD: begin
        if (status.out_free) begin
          ctrl.add_wr = !status.count_full;
          ctrl.emit   = 1'b1;
          ctrl.kind   = status.count_full ? KIND_FULL : KIND_OK;
          state_nxt   = ST_IDLE;
        end
      end
      ST_PRIME: begin
        ctrl.scan_adv = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.cmd == CMD_REMOVE) begin
          if (!status.data_vld) begin
            state_nxt = ST_DONE;
          end else if (status.hit) begin
            ctrl.hit_cap    = 1'b1;
            ctrl.fetch_last = 1'b1;
            state_nxt       = ST_MOVE;
          end else begin
            ctrl.scan_adv = 1'b1;
          end
        end else begin
          if (!status.data_vld || status.made_eq_limit) begin
            state_nxt = ST_DONE;
          end else if (!status.entry_free) begin
            ctrl.scan_adv = 1'b1;
          end else if (!status.pend_vld || status.out_free) begin
            ctrl.grant    = 1'b1;
            ctrl.scan_adv = 1'b1;
            ctrl.emit     = status.pend_vld;
            ctrl.kind     = KIND_GRANT_MID;
          end
        end
      end
      ST_MOVE: begin
        if (status.out_free) begin
          ctrl.move_wr = 1'b1;
          ctrl.emit    = 1'b1;
          ctrl.kind    = KIND_OK;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          ctrl.emit = 1'b1;
          if (status.cmd == CMD_ALLOC) begin
            ctrl.kind = status.pend_vld ? KIND_GRANT_LAST : KIND_NO_GRANT;
          end else begin
            ctrl.kind = KIND_NOTFOUND;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/node_pool_allocator.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_tvalid/in_tready  tuser command, tdata ident and max grants
// out_     output     out_tvalid/out_tready tuser grant flag, tdata result, tlast last
//
// One command is taken at a time; the next is accepted once the last result is registered.
// Remove and allocate scan the table through one registered memory read port,
// one entry per cycle.
// Reset clears the entry count and the output register; the table needs no clearing.
// A stalled output holds the scan of an allocate only when a second grant is ready.
module node_pool_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: node_ident[15:0], max_grants[20:16].
  input  logic [npa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [npa_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: result_code[1:0], granted_ident[17:2], grant_total[22:18],
  // pool_count[27:23].
  output logic [npa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0: grant_valid[0].
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast
);
  import npa_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  npa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .ctrl      (ctrl)
  );

  npa_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .ctrl       (ctrl),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
